### rtl/llqm_pkg.sv
// Shared types and constants of the linked-list queue manager.
package llqm_pkg;

  localparam int DATA_W  = 32;
  localparam int FIELD_W = 9;
  localparam int ADDR_W  = 3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [ADDR_W-3:0] REG_QUEUE_LIMIT = 1'b0;
  localparam logic [FIELD_W-1:0] QUEUE_LIMIT_RESET = 9'd256;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_AT_LIMIT    = 2'd1,
    ST_POOL_EMPTY  = 2'd2,
    ST_QUEUE_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        queue_select;
    logic [DATA_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    status_t            status;
    logic [FIELD_W-1:0] queue_count;
    logic               queue_empty;
    logic [FIELD_W-1:0] free_nodes;
  } rsp_t;

endpackage

### rtl/llqm_ram.sv
// Generic single-write, single-read memory with a registered read port.
module llqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/llqm_cfg.sv
// APB register block holding the per-queue entry limit.
module llqm_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llqm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [llqm_pkg::FIELD_W-1:0] queue_limit
);
  import llqm_pkg::*;

  logic                  wr_en;
  logic [ADDR_W-3:0]     reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= QUEUE_LIMIT_RESET;
    end else if (wr_en && reg_index == REG_QUEUE_LIMIT) begin
      queue_limit <= pwdata[FIELD_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_QUEUE_LIMIT: prdata = {{(32-FIELD_W){1'b0}}, queue_limit};
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/llqm_engine.sv
// Request sequencer with the queue table, free stack and node memories.
module llqm_engine #(
  parameter int POOL_NODES  = 256,
  parameter int QUEUE_COUNT = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [llqm_pkg::FIELD_W-1:0] queue_limit,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  llqm_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output llqm_pkg::rsp_t               rsp
);
  import llqm_pkg::*;

  localparam int NW = $clog2(POOL_NODES);
  localparam int CW = $clog2(POOL_NODES + 1);
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int LW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int TW = 2 * NW + CW;

  state_t            state, state_next;
  logic              kind_r;
  logic [QW-1:0]     q_r, q_in;
  logic [DATA_W-1:0] wval_r;
  logic [CW-1:0]     free_depth, low_water, depth_m1;
  logic [QUEUE_COUNT-1:0] qvalid;

  logic [TW-1:0]     tbl_rdata, tbl_entry, tbl_wdata;
  logic [QW-1:0]     tbl_raddr;
  logic              tbl_we;
  logic [NW-1:0]     t_head, t_tail;
  logic [CW-1:0]     t_count;

  logic [NW-1:0]     fs_rdata, fs_node, fs_waddr, fs_wdata;
  logic              fs_we;
  logic [DATA_W-1:0] val_rdata;
  logic              val_we;
  logic [NW-1:0]     link_rdata, link_waddr;
  logic              link_we;

  logic              is_read, q_empty, at_limit, pool_empty, slot_free, fin, commit;
  status_t           status_c;
  logic [NW-1:0]     new_head;
  logic [CW-1:0]     new_count, new_depth;
  logic [LW-1:0]     count_ext, depth_ext;
  rsp_t              rsp_next;

  always_comb begin
    logic [31:0] sel_ext;
    logic [31:0] q_full;
    sel_ext = 32'(req.queue_select);
    if (QUEUE_COUNT == 1) begin
      q_full = '0;
    end else if (sel_ext >= 32'(QUEUE_COUNT)) begin
      q_full = sel_ext - 32'(QUEUE_COUNT);
    end else begin
      q_full = sel_ext;
    end
    q_in = q_full[QW-1:0];
  end

  assign tbl_raddr = (state == S_IDLE) ? q_in : q_r;
  assign tbl_entry = qvalid[q_r] ? tbl_rdata : '0;
  assign t_head    = tbl_entry[TW-1 -: NW];
  assign t_tail    = tbl_entry[CW +: NW];
  assign t_count   = tbl_entry[CW-1:0];

  assign depth_m1 = free_depth - CW'(1);
  assign fs_node  = (free_depth == low_water) ? depth_m1[NW-1:0] : fs_rdata;

  assign is_read    = (kind_r == KIND_READ);
  assign q_empty    = (t_count == '0);
  assign at_limit   = LW'(t_count) >= LW'(queue_limit);
  assign pool_empty = (free_depth == '0);
  assign slot_free  = !rsp_valid || rsp_ready;

  llqm_ram #(.WIDTH(TW), .DEPTH(QUEUE_COUNT)) u_queue_table (
    .clk(clk), .we(tbl_we), .waddr(q_r), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  llqm_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_free_stack (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(depth_m1[NW-1:0]), .rdata(fs_rdata)
  );

  llqm_ram #(.WIDTH(DATA_W), .DEPTH(POOL_NODES)) u_node_value (
    .clk(clk), .we(val_we), .waddr(fs_node), .wdata(wval_r),
    .raddr(t_head), .rdata(val_rdata)
  );

  llqm_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_node_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(fs_node),
    .raddr(t_head), .rdata(link_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_read && !q_empty) begin
          state_next = S_FETCH;
        end else if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    fin       = 1'b0;
    unique case (state)
      S_IDLE:  req_ready = 1'b1;
      S_EXEC:  fin = slot_free && !(is_read && !q_empty);
      S_FETCH: fin = slot_free;
      default: fin = 1'b0;
    endcase
  end

  always_comb begin
    status_c = ST_OK;
    if (!is_read) begin
      if (at_limit) begin
        status_c = ST_AT_LIMIT;
      end else if (pool_empty) begin
        status_c = ST_POOL_EMPTY;
      end
    end else if (q_empty) begin
      status_c = ST_QUEUE_EMPTY;
    end
    commit = fin && (status_c == ST_OK);

    new_head  = t_head;
    new_count = t_count;
    new_depth = free_depth;
    if (status_c == ST_OK) begin
      if (is_read) begin
        new_count = t_count - CW'(1);
        if (t_count > CW'(1)) begin
          new_head = link_rdata;
        end
        if (free_depth < CW'(POOL_NODES)) begin
          new_depth = free_depth + CW'(1);
        end
      end else begin
        new_count = t_count + CW'(1);
        new_depth = depth_m1;
        if (q_empty) begin
          new_head = fs_node;
        end
      end
    end

    tbl_we     = commit;
    tbl_wdata  = {new_head, (is_read ? t_tail : fs_node), new_count};
    val_we     = commit && !is_read;
    link_we    = commit && !is_read && !q_empty;
    link_waddr = t_tail;
    fs_we      = commit && is_read && (free_depth < CW'(POOL_NODES));
    fs_waddr   = free_depth[NW-1:0];
    fs_wdata   = t_head;

    count_ext = LW'(new_count);
    depth_ext = LW'(new_depth);
    rsp_next.read_value  = (is_read && status_c == ST_OK) ? val_rdata : '0;
    rsp_next.status      = status_c;
    rsp_next.queue_count = count_ext[FIELD_W-1:0];
    rsp_next.queue_empty = (new_count == '0);
    rsp_next.free_nodes  = depth_ext[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      free_depth <= CW'(POOL_NODES);
      low_water  <= CW'(POOL_NODES);
      qvalid     <= '0;
    end else begin
      state <= state_next;
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (commit) begin
        free_depth  <= new_depth;
        qvalid[q_r] <= 1'b1;
        if (new_depth < low_water) begin
          low_water <= new_depth;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      kind_r <= req.kind;
      q_r    <= q_in;
      wval_r <= req.write_value;
    end
    if (fin) begin
      rsp <= rsp_next;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    free_depth <= CW'(POOL_NODES))
    else $error("free stack depth beyond pool size");

  a_low_water: assert property (@(posedge clk) disable iff (rst)
    low_water <= free_depth)
    else $error("low-water mark above free stack depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_EXEC && !req_ready))
    else $error("accepted request not in execution");

  a_write_pop: assert property (@(posedge clk) disable iff (rst)
    (commit && !is_read) |=> (free_depth == $past(depth_m1)))
    else $error("successful write did not pop one free node");

endmodule

### rtl/linked_list_queue_manager_top.sv
// Top level of the linked-list queue manager: APB registers and request engine.
// QUEUE_COUNT FIFO queues of 32-bit values share a pool of POOL_NODES linked
// nodes; free nodes sit on a stack in memory and the top one is taken first.
// The queue-table and free-stack memories are read at the edge that accepts a
// request, and the EXEC state then decides, writes back and registers the
// response of a write request or of a refused request. A successful read also
// passes through the FETCH state, because the head node's value and link
// come from pool memory only after the queue table has given the head index.
// One request is worked on at a time, and the engine goes back to the idle
// state, the only state that accepts a request, once a response is registered.
// A new request is accepted while the previous response still waits in the
// output register.
// The response stalls in place while an earlier response has not been taken.
// No clearing pass follows reset: the queue table has a valid bit per queue and
// the free stack tracks its low-water mark, so requests are taken at once.
module linked_list_queue_manager_top #(
  parameter int POOL_NODES  = 256,
  parameter int QUEUE_COUNT = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [llqm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  llqm_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output llqm_pkg::rsp_t               rsp
);
  import llqm_pkg::*;

  logic [FIELD_W-1:0] queue_limit;

  llqm_cfg u_cfg (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .queue_limit(queue_limit)
  );

  llqm_engine #(.POOL_NODES(POOL_NODES), .QUEUE_COUNT(QUEUE_COUNT)) u_engine (
    .clk(clk), .rst(rst), .queue_limit(queue_limit),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

endmodule
